// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/doiu_pkg.sv =====
package doiu_pkg;

  localparam int IDX_W      = 11;
  localparam int KIND_W     = 2;
  localparam int VERD_W     = 2;
  localparam int PORT_CW    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ORIENT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SOS      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INCIRCLE = 2'd3;

  localparam logic [VERD_W-1:0] VERDICT_NEG  = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_ZERO = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_POS  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INF_X       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INF_Y       = 2'd2;

  // Side information that rides along the pipeline with each query.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              inf_abc;
    logic              inf_ab;
    logic              inf_d;
    logic              sos_pos;
    logic [VERD_W-1:0] ori;
  } tag_t;

  function automatic logic [VERD_W-1:0] flip_verdict(input logic [VERD_W-1:0] v);
    logic [VERD_W-1:0] r;
    case (v)
      VERDICT_NEG: r = VERDICT_POS;
      VERDICT_POS: r = VERDICT_NEG;
      default:     r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/doiu_if.sv =====
interface doiu_req_if;
  logic                             valid;
  logic                             ready;
  logic [doiu_pkg::KIND_W-1:0]      kind;
  logic [doiu_pkg::IDX_W-1:0]       idx_a;
  logic [doiu_pkg::IDX_W-1:0]       idx_b;
  logic [doiu_pkg::IDX_W-1:0]       idx_c;
  logic [doiu_pkg::IDX_W-1:0]       idx_d;
  logic signed [doiu_pkg::PORT_CW-1:0] coord_x;
  logic signed [doiu_pkg::PORT_CW-1:0] coord_y;

  modport source (output valid, kind, idx_a, idx_b, idx_c, idx_d, coord_x, coord_y,
                  input ready);
  modport sink (input valid, kind, idx_a, idx_b, idx_c, idx_d, coord_x, coord_y,
                output ready);
endinterface

interface doiu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [doiu_pkg::VERD_W-1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

// ===== rtl/doiu_mul.sv =====
module doiu_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int CH = 24;
  localparam int N  = (W + CH - 1) / CH;
  localparam int NC = N * CH;

  logic [NC-1:0]     ma, mb;
  logic              neg1, neg2, neg3, neg4;
  logic [2*CH-1:0]   pp [N][N];
  logic [2*NC-1:0]   row [N];
  logic [2*NC-1:0]   row_next [N];
  logic [2*NC-1:0]   mag, mag_next;

  // sum partial products of one row, then the rows
  always_comb begin
    for (int i = 0; i < N; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < N; j++) begin
        row_next[i] = row_next[i] + ((2*NC)'(pp[i][j]) << (j * CH));
      end
    end
    mag_next = '0;
    for (int i = 0; i < N; i++) begin
      mag_next = mag_next + (row[i] << (i * CH));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= NC'($unsigned(a[W-1] ? -a : a));
      mb   <= NC'($unsigned(b[W-1] ? -b : b));
      neg1 <= a[W-1] ^ b[W-1];
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          pp[i][j] <= ma[i*CH +: CH] * mb[j*CH +: CH];
        end
      end
      neg2 <= neg1;
      row  <= row_next;
      neg3 <= neg2;
      mag  <= mag_next;
      neg4 <= neg3;
      p    <= (2*W)'(neg4 ? (~mag + 1'b1) : mag);
    end
  end

endmodule

// ===== rtl/delaunay_orient_incircle_unit.sv =====
// Throughput: one item per cycle unless rsp stalls; loads and queries may alternate freely.
// The pipeline depth is set by the fetch/difference stages and two 5-stage multipliers.
// rsp backpressure stalls the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears valid bits and config registers; the point
// table is not cleared and reads of unwritten entries are undefined.
module delaunay_orient_incircle_unit #(
  parameter int POINT_DEPTH = 1024,
  parameter int COORD_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [doiu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [doiu_pkg::CFG_DATA_W-1:0]   cfg_data,
  doiu_req_if.sink                          req,
  doiu_rsp_if.source                        rsp
);

`include "assert_macros.svh"

  localparam int AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
  localparam int CW = COORD_BITS;
  localparam int D  = CW + 1;      // coordinate difference
  localparam int P  = 2 * D;       // first products
  localparam int L  = 2 * D + 1;   // lifted terms and 2x2 minors
  localparam int T  = 4 * L + 2;   // incircle determinant
  localparam int NS = 15;          // pipeline stages
  localparam int NM = 14;          // first-level multipliers

  // Configuration registers
  logic [doiu_pkg::IDX_W-1:0] point_count;
  logic [CW-1:0]              inf_x, inf_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      inf_x       <= '0;
      inf_y       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        doiu_pkg::REG_POINT_COUNT: point_count <= cfg_data[doiu_pkg::IDX_W-1:0];
        doiu_pkg::REG_INF_X:       inf_x       <= cfg_data[CW-1:0];
        doiu_pkg::REG_INF_Y:       inf_y       <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipeline moves unless the output is held.
  logic            adv;
  logic [NS-1:0]   vld;
  doiu_pkg::tag_t  tg [NS];

  assign adv       = !vld[NS-1] || rsp.ready;
  assign req.ready = adv;

  // Point table: two copies, each with two read ports, so four vertices are
  // fetched in the same cycle. Loads write both copies.
  logic [2*CW-1:0] mem0 [POINT_DEPTH];
  logic [2*CW-1:0] mem1 [POINT_DEPTH];
  logic [2*CW-1:0] rd1 [4];
  logic            ld_wr;
  logic [2*CW-1:0] ld_data;

  assign ld_wr   = req.valid && adv && (req.kind == doiu_pkg::KIND_LOAD)
                   && (32'(req.idx_a) < POINT_DEPTH);
  assign ld_data = {req.coord_y[CW-1:0], req.coord_x[CW-1:0]};

  always_ff @(posedge clk) begin
    if (ld_wr) begin
      mem0[AW'(req.idx_a)] <= ld_data;
      mem1[AW'(req.idx_a)] <= ld_data;
    end
    if (adv) begin
      rd1[0] <= mem0[AW'(req.idx_a)];
      rd1[1] <= mem0[AW'(req.idx_b)];
      rd1[2] <= mem1[AW'(req.idx_c)];
      rd1[3] <= mem1[AW'(req.idx_d)];
    end
  end

  // Stage 1: index flags
  logic [3:0][doiu_pkg::IDX_W-1:0] idx_in, idx1, idx2;
  logic [3:0]                      inf_in, oob_in, inf1, oob1, inf2;
  doiu_pkg::tag_t                  tag_in;

  assign idx_in = {req.idx_d, req.idx_c, req.idx_b, req.idx_a};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      inf_in[i] = (idx_in[i] == point_count);
      oob_in[i] = !inf_in[i] && (32'(idx_in[i]) >= POINT_DEPTH);
    end
    tag_in         = '0;
    tag_in.kind    = req.kind;
    tag_in.inf_abc = |inf_in[2:0];
    tag_in.inf_ab  = |inf_in[1:0];
    tag_in.inf_d   = inf_in[3];
  end

  // Stage 2: resolve coordinates (infinite point, out of range, table)
  logic signed [CW-1:0] px2 [4];
  logic signed [CW-1:0] py2 [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1 <= idx_in;
      inf1 <= inf_in;
      oob1 <= oob_in;
      idx2 <= idx1;
      inf2 <= inf1;
      for (int i = 0; i < 4; i++) begin
        if (inf1[i]) begin
          px2[i] <= inf_x;
          py2[i] <= inf_y;
        end else if (oob1[i]) begin
          px2[i] <= '0;
          py2[i] <= '0;
        end else begin
          px2[i] <= rd1[i][CW-1:0];
          py2[i] <= rd1[i][2*CW-1:CW];
        end
      end
    end
  end

  // Stage 3: differences. The orientation triple is (a, b, c) except for an
  // incircle on a triangle holding the infinite vertex, where the other two
  // vertices are taken in cyclic order against d.
  logic [1:0]           sel_p, sel_q, sel_r;
  logic [1:0]           ord [3];
  logic [doiu_pkg::IDX_W-1:0] key [3];
  logic [1:0]           tord;
  logic [doiu_pkg::IDX_W-1:0] tkey;
  logic                 par;

  always_comb begin
    sel_p = 2'd0;
    sel_q = 2'd1;
    sel_r = 2'd2;
    tkey  = '0;
    tord  = 2'd0;
    if (tg[1].kind == doiu_pkg::KIND_INCIRCLE && |inf2[2:0]) begin
      sel_r = 2'd3;
      if (inf2[0]) begin
        sel_p = 2'd1;
        sel_q = 2'd2;
      end else if (inf2[1]) begin
        sel_p = 2'd2;
        sel_q = 2'd0;
      end
    end
    // sort the three vertex indices, tracking swap parity
    for (int i = 0; i < 3; i++) begin
      key[i] = idx2[i];
      ord[i] = 2'(i);
    end
    par = 1'b0;
    if (key[0] > key[1]) begin
      tkey = key[0]; key[0] = key[1]; key[1] = tkey;
      tord = ord[0]; ord[0] = ord[1]; ord[1] = tord;
      par = !par;
    end
    if (key[0] > key[2]) begin
      tkey = key[0]; key[0] = key[2]; key[2] = tkey;
      tord = ord[0]; ord[0] = ord[2]; ord[2] = tord;
      par = !par;
    end
    if (key[1] > key[2]) begin
      tkey = key[1]; key[1] = key[2]; key[2] = tkey;
      tord = ord[1]; ord[1] = ord[2]; ord[2] = tord;
      par = !par;
    end
  end

  logic signed [D-1:0] o_ax, o_ay, o_bx, o_by;
  logic signed [D-1:0] adx, ady, bdx, bdy, cdx, cdy;
  logic signed [D-1:0] sr1, sr2, sr3;
  logic                spar;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_ax <= D'(px2[sel_p]) - D'(px2[sel_r]);
      o_ay <= D'(py2[sel_p]) - D'(py2[sel_r]);
      o_bx <= D'(px2[sel_q]) - D'(px2[sel_r]);
      o_by <= D'(py2[sel_q]) - D'(py2[sel_r]);
      adx  <= D'(px2[0]) - D'(px2[3]);
      ady  <= D'(py2[0]) - D'(py2[3]);
      bdx  <= D'(px2[1]) - D'(px2[3]);
      bdy  <= D'(py2[1]) - D'(py2[3]);
      cdx  <= D'(px2[2]) - D'(px2[3]);
      cdy  <= D'(py2[2]) - D'(py2[3]);
      sr1  <= D'(px2[ord[2]]) - D'(px2[ord[1]]);
      sr2  <= D'(py2[ord[1]]) - D'(py2[ord[2]]);
      sr3  <= D'(px2[ord[0]]) - D'(px2[ord[2]]);
      spar <= par;
    end
  end

  // Tie-break sign: first nonzero difference, flipped by the swap parity
  logic sos_pos;

  always_comb begin
    if (sr1 != '0) begin
      sos_pos = !sr1[D-1];
    end else if (sr2 != '0) begin
      sos_pos = !sr2[D-1];
    end else if (sr3 != '0) begin
      sos_pos = !sr3[D-1];
    end else begin
      sos_pos = 1'b1;
    end
    sos_pos = sos_pos ^ spar;
  end

  // Stages 4-8: all 2x2 products in parallel
  logic signed [D-1:0] ma1 [NM];
  logic signed [D-1:0] mb1 [NM];
  logic signed [P-1:0] mp1 [NM];

  assign ma1[0]  = o_ax;  assign mb1[0]  = o_by;
  assign ma1[1]  = o_ay;  assign mb1[1]  = o_bx;
  assign ma1[2]  = adx;   assign mb1[2]  = adx;
  assign ma1[3]  = ady;   assign mb1[3]  = ady;
  assign ma1[4]  = bdx;   assign mb1[4]  = bdx;
  assign ma1[5]  = bdy;   assign mb1[5]  = bdy;
  assign ma1[6]  = cdx;   assign mb1[6]  = cdx;
  assign ma1[7]  = cdy;   assign mb1[7]  = cdy;
  assign ma1[8]  = bdx;   assign mb1[8]  = cdy;
  assign ma1[9]  = cdx;   assign mb1[9]  = bdy;
  assign ma1[10] = cdx;   assign mb1[10] = ady;
  assign ma1[11] = adx;   assign mb1[11] = cdy;
  assign ma1[12] = adx;   assign mb1[12] = bdy;
  assign ma1[13] = bdx;   assign mb1[13] = ady;

  for (genvar g = 0; g < NM; g++) begin : g_mul1
    doiu_mul #(.W(D)) u_mul (
      .clk (clk),
      .en  (adv),
      .a   (ma1[g]),
      .b   (mb1[g]),
      .p   (mp1[g])
    );
  end

  // Stage 9: orientation sign, lifted terms and minors
  logic signed [L-1:0] odet;
  logic [doiu_pkg::VERD_W-1:0] ori_sign;
  logic signed [L-1:0] al, bl, cl, bc, ca, ab;

  assign odet = L'(mp1[0]) - L'(mp1[1]);

  always_comb begin
    if (odet[L-1]) begin
      ori_sign = doiu_pkg::VERDICT_NEG;
    end else if (odet == '0) begin
      ori_sign = doiu_pkg::VERDICT_ZERO;
    end else begin
      ori_sign = doiu_pkg::VERDICT_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      al <= L'(mp1[2])  + L'(mp1[3]);
      bl <= L'(mp1[4])  + L'(mp1[5]);
      cl <= L'(mp1[6])  + L'(mp1[7]);
      bc <= L'(mp1[8])  - L'(mp1[9]);
      ca <= L'(mp1[10]) - L'(mp1[11]);
      ab <= L'(mp1[12]) - L'(mp1[13]);
    end
  end

  // Stages 10-14: lifted terms times minors
  logic signed [2*L-1:0] q0, q1, q2;

  doiu_mul #(.W(L)) u_mul_a (.clk(clk), .en(adv), .a(al), .b(bc), .p(q0));
  doiu_mul #(.W(L)) u_mul_b (.clk(clk), .en(adv), .a(bl), .b(ca), .p(q1));
  doiu_mul #(.W(L)) u_mul_c (.clk(clk), .en(adv), .a(cl), .b(ab), .p(q2));

  // Stage 15: incircle sign and final verdict
  logic signed [T-1:0]          det;
  logic [doiu_pkg::VERD_W-1:0]  det_sign, final_v, verdict;
  doiu_pkg::tag_t               tf;

  assign det = T'(q0) + T'(q1) + T'(q2);
  assign tf  = tg[NS-2];

  always_comb begin
    if (det[T-1]) begin
      det_sign = doiu_pkg::VERDICT_NEG;
    end else if (det == '0) begin
      det_sign = doiu_pkg::VERDICT_ZERO;
    end else begin
      det_sign = doiu_pkg::VERDICT_POS;
    end
    if (tf.kind == doiu_pkg::KIND_INCIRCLE) begin
      if (tf.inf_d) begin
        final_v = doiu_pkg::VERDICT_NEG;
      end else if (tf.inf_abc) begin
        final_v = tf.ori;
      end else begin
        final_v = det_sign;
      end
    end else begin
      final_v = tf.inf_abc ? doiu_pkg::flip_verdict(tf.ori) : tf.ori;
      if (tf.kind == doiu_pkg::KIND_SOS) begin
        if (final_v == doiu_pkg::VERDICT_ZERO) begin
          final_v = tf.sos_pos ? doiu_pkg::VERDICT_POS : doiu_pkg::VERDICT_NEG;
        end
        if (tf.inf_ab) begin
          final_v = doiu_pkg::flip_verdict(final_v);
        end
      end
    end
  end

  // Valid bits and side tags; tie-break sign joins at stage 4, orientation
  // sign at stage 9.
  doiu_pkg::tag_t tg3_in, tg8_in;

  always_comb begin
    tg3_in         = tg[2];
    tg3_in.sos_pos = sos_pos;
    tg8_in         = tg[7];
    tg8_in.ori     = ori_sign;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], req.valid && (req.kind != doiu_pkg::KIND_LOAD)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tg[0] <= tag_in;
      for (int i = 1; i < NS; i++) begin
        if (i == 3) begin
          tg[i] <= tg3_in;
        end else if (i == 8) begin
          tg[i] <= tg8_in;
        end else begin
          tg[i] <= tg[i-1];
        end
      end
      verdict <= final_v;
    end
  end

  assign rsp.valid   = vld[NS-1];
  assign rsp.verdict = verdict;

  `ASSERT_IMP(a_verdict_code, rsp.valid,
    rsp.verdict == doiu_pkg::VERDICT_NEG || rsp.verdict == doiu_pkg::VERDICT_ZERO ||
    rsp.verdict == doiu_pkg::VERDICT_POS, "illegal verdict code")
  `ASSERT_NXT(a_load_no_result,
    req.valid && req.ready && req.kind == doiu_pkg::KIND_LOAD, !vld[0],
    "load transaction entered the query pipeline")
  `ASSERT_NXT(a_stall_holds, !adv, $stable(vld) && $stable(rsp.verdict),
    "pipeline moved during a stall")

endmodule
